// ===== hw/rtl/ilt_pkg.sv =====
// Types and constants shared by the incidence list transpose core.
package ilt_pkg;

  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_DEG     = 32;

  localparam int ROW_W = 8;
  localparam int COL_W = 8;
  localparam int CNT_W = 5;
  localparam int REG_W = 9;
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_ROWS_IN_USE    = 1'd0;
  localparam logic [IDX_W-1:0] REG_COLUMNS_IN_USE = 1'd1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ROW_LONG  = 3'd1,
    ST_COL_FULL  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CNT  = 3'b010,
    S_BKT  = 3'b100
  } state_t;

  // Packed from the top down; row_out sits in the lowest bits.
  typedef struct packed {
    logic             error_seen;
    logic [2:0]       status;
    logic [CNT_W-1:0] max_column_count;
    logic [CNT_W-1:0] column_count;
    logic [ROW_W-1:0] row_out;
  } result_t;

endpackage

// ===== hw/rtl/incidence_list_transpose_core.sv =====
// Incidence list transpose core: column count and bucket memories with insert/read/clear.
//
//  channel | direction | handshake          | contents
//  in_     | input     | tvalid/tready      | tdata: row_index, column_index, slot; tuser: opcode
//  out_    | output    | tvalid/tready      | tdata: row_out, column_count, max_column_count,
//          |           |                    |        status, error_seen
//  cfg_    | input     | we (no wait)       | index 0 rows_in_use, 1 columns_in_use
//
// One item in flight. Insert, clear and failed reads pass a count memory read, then the update;
// a good read passes a count read, then a bucket read.
// The output register lets the next item be taken while a result waits.
// A stalled output holds the core in its final state until the register frees.
// Reset (rst_n, synchronous) clears counts via per-column valid bits; buckets stay unset.
module incidence_list_transpose_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] row_index, [15:8] column_index, [20:16] slot
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] row_out, [12:8] column_count,
                                  // [17:13] max_column_count, [20:18] status, [21] error_seen
  input  logic                        cfg_we,
  input  logic [ilt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [ilt_pkg::REG_W-1:0]   cfg_wdata
);

  localparam int BKT_AW = ilt_pkg::COL_W + ilt_pkg::CNT_W;

  logic [ilt_pkg::CNT_W-1:0] cnt_mem [ilt_pkg::MAX_COLUMNS];
  logic [ilt_pkg::ROW_W-1:0] bkt_mem [ilt_pkg::MAX_COLUMNS * ilt_pkg::MAX_DEG];

  ilt_pkg::state_t state_r, state_nxt;
  logic [1:0]                  op_r;
  logic [ilt_pkg::ROW_W-1:0]   row_r;
  logic [ilt_pkg::COL_W-1:0]   col_r;
  logic [ilt_pkg::CNT_W-1:0]   slot_r;
  logic [ilt_pkg::CNT_W-1:0]   cnt_q_r;
  logic [ilt_pkg::ROW_W-1:0]   bkt_q_r;
  logic [ilt_pkg::MAX_COLUMNS-1:0] cnt_vld_r, cnt_vld_nxt;
  logic [ilt_pkg::CNT_W-1:0]   largest_r, largest_nxt;
  logic [ilt_pkg::ROW_W-1:0]   prev_row_r, prev_row_nxt;
  logic                        have_prev_r, have_prev_nxt;
  logic [ilt_pkg::CNT_W-1:0]   row_len_r, row_len_nxt;
  logic                        sticky_r, sticky_nxt;
  logic [ilt_pkg::REG_W-1:0]   rows_in_use_r, cols_in_use_r;
  logic                        out_valid_r, out_valid_nxt;
  ilt_pkg::result_t            out_res_r, out_res_nxt;

  logic                        in_acc, out_free;
  logic                        cnt_we, bkt_we, bkt_re;
  logic [ilt_pkg::CNT_W-1:0]   cnt_cur, cnt_wdata;
  logic [ilt_pkg::CNT_W-1:0]   len_eff;
  logic [ilt_pkg::CNT_W:0]     cnt_inc, len_inc;
  logic                        col_ok, row_ok, new_row;

  assign in_tready  = (state_r == ilt_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  assign cnt_cur = cnt_vld_r[col_r] ? cnt_q_r : '0;
  assign col_ok  = ({1'b0, col_r} < cols_in_use_r) &&
                   ({1'b0, col_r} < ilt_pkg::REG_W'(ilt_pkg::MAX_COLUMNS));
  assign row_ok  = ({1'b0, row_r} < rows_in_use_r) &&
                   ({1'b0, row_r} < ilt_pkg::REG_W'(ilt_pkg::MAX_ROWS));
  assign new_row = !have_prev_r || (row_r != prev_row_r);
  assign len_eff = new_row ? '0 : row_len_r;
  assign len_inc = {1'b0, len_eff} + 1'b1;
  assign cnt_inc = {1'b0, cnt_cur} + 1'b1;
  assign cnt_wdata = cnt_inc[ilt_pkg::CNT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_vld_nxt   = cnt_vld_r;
    largest_nxt   = largest_r;
    prev_row_nxt  = prev_row_r;
    have_prev_nxt = have_prev_r;
    row_len_nxt   = row_len_r;
    sticky_nxt    = sticky_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    cnt_we        = 1'b0;
    bkt_we        = 1'b0;
    bkt_re        = 1'b0;
    case (state_r)
      ilt_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = ilt_pkg::S_CNT;
        end
      end
      ilt_pkg::S_CNT: begin
        if (op_r == ilt_pkg::OP_READ && col_ok && slot_r < cnt_cur) begin
          bkt_re    = 1'b1;
          state_nxt = ilt_pkg::S_BKT;
        end else if (out_free) begin
          state_nxt     = ilt_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          out_res_nxt   = '0;
          case (op_r)
            ilt_pkg::OP_INSERT: begin
              if (!row_ok || !col_ok) begin
                sticky_nxt = 1'b1;
                out_res_nxt.column_count = col_ok ? cnt_cur : '0;
                out_res_nxt.status = ilt_pkg::ST_RANGE;
              end else begin
                prev_row_nxt  = row_r;
                have_prev_nxt = 1'b1;
                row_len_nxt   = len_eff;
                out_res_nxt.column_count = cnt_cur;
                if (len_inc >= (ilt_pkg::CNT_W+1)'(ilt_pkg::MAX_DEG)) begin
                  sticky_nxt = 1'b1;
                  out_res_nxt.status = ilt_pkg::ST_ROW_LONG;
                end else if (cnt_inc >= (ilt_pkg::CNT_W+1)'(ilt_pkg::MAX_DEG)) begin
                  sticky_nxt = 1'b1;
                  out_res_nxt.status = ilt_pkg::ST_COL_FULL;
                end else begin
                  cnt_we = 1'b1;
                  bkt_we = 1'b1;
                  cnt_vld_nxt[col_r] = 1'b1;
                  row_len_nxt = len_inc[ilt_pkg::CNT_W-1:0];
                  if (cnt_wdata > largest_r) begin
                    largest_nxt = cnt_wdata;
                  end
                  out_res_nxt.column_count = cnt_wdata;
                  out_res_nxt.status = ilt_pkg::ST_OK;
                end
              end
              out_res_nxt.max_column_count = largest_nxt;
              out_res_nxt.error_seen       = sticky_nxt;
            end
            ilt_pkg::OP_READ: begin
              if (!col_ok) begin
                out_res_nxt.status = ilt_pkg::ST_RANGE;
              end else begin
                out_res_nxt.column_count = cnt_cur;
                out_res_nxt.status = ilt_pkg::ST_EMPTY;
              end
              out_res_nxt.max_column_count = largest_r;
              out_res_nxt.error_seen       = sticky_r;
            end
            ilt_pkg::OP_CLEAR: begin
              cnt_vld_nxt   = '0;
              largest_nxt   = '0;
              have_prev_nxt = 1'b0;
              row_len_nxt   = '0;
              sticky_nxt    = 1'b0;
            end
            default: begin
              out_res_nxt.max_column_count = largest_r;
              out_res_nxt.error_seen       = sticky_r;
            end
          endcase
        end
      end
      ilt_pkg::S_BKT: begin
        if (out_free) begin
          state_nxt     = ilt_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          out_res_nxt.row_out          = bkt_q_r;
          out_res_nxt.column_count     = cnt_cur;
          out_res_nxt.max_column_count = largest_r;
          out_res_nxt.status           = ilt_pkg::ST_OK;
          out_res_nxt.error_seen       = sticky_r;
        end
      end
      default: begin
        state_nxt = ilt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ilt_pkg::S_IDLE;
      cnt_vld_r     <= '0;
      largest_r     <= '0;
      prev_row_r    <= '0;
      have_prev_r   <= 1'b0;
      row_len_r     <= '0;
      sticky_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      rows_in_use_r <= ilt_pkg::REG_W'(ilt_pkg::MAX_ROWS);
      cols_in_use_r <= ilt_pkg::REG_W'(ilt_pkg::MAX_COLUMNS);
    end else begin
      state_r     <= state_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      largest_r   <= largest_nxt;
      prev_row_r  <= prev_row_nxt;
      have_prev_r <= have_prev_nxt;
      row_len_r   <= row_len_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ilt_pkg::REG_ROWS_IN_USE:    rows_in_use_r <= cfg_wdata;
          ilt_pkg::REG_COLUMNS_IN_USE: cols_in_use_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    if (in_acc) begin
      op_r   <= in_tuser;
      row_r  <= in_tdata[7:0];
      col_r  <= in_tdata[15:8];
      slot_r <= in_tdata[20:16];
    end
  end

  // count memory: read on accept, written back on a successful insert
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[col_r] <= cnt_wdata;
    end
    if (in_acc) begin
      cnt_q_r <= cnt_mem[in_tdata[15:8]];
    end
  end

  // bucket memory: column c owns entries c*MAX_DEG .. c*MAX_DEG+MAX_DEG-1
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[BKT_AW'({col_r, cnt_cur})] <= row_r;
    end
    if (bkt_re) begin
      bkt_q_r <= bkt_mem[BKT_AW'({col_r, slot_r})];
    end
  end

endmodule
